// ===== hdl/cfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and codes of the call frame stack: request and result
// payloads, request kinds and error codes.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int unsigned STACK_WORDS_DEF = 1024;
  localparam int unsigned HEADER_WORDS    = 2;

  // request kinds
  localparam logic [2:0] KIND_CALL        = 3'd0;
  localparam logic [2:0] KIND_RETURN      = 3'd1;
  localparam logic [2:0] KIND_READ_WORD   = 3'd2;
  localparam logic [2:0] KIND_READ_DWORD  = 3'd3;
  localparam logic [2:0] KIND_WRITE_WORD  = 3'd4;
  localparam logic [2:0] KIND_WRITE_DWORD = 3'd5;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_SCOPE     = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  index;
    logic [31:0] value_low;
    logic [31:0] value_high;
    logic [31:0] return_address;
    logic [7:0]  locals_count;
  } cfs_req_t;

  typedef struct packed {
    logic [31:0] read_low;
    logic [31:0] read_high;
    logic [31:0] resume_address;
    logic [1:0]  error;
  } cfs_res_t;

endpackage

// ===== hdl/call_frame_stack_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_frame_stack_core
// Frame stack for a virtual machine, kept in a downward-growing word memory.
// Sequence: an accepted request passes SECOND and FINISH; its result is
//   registered as FINISH ends with the output slot free. A new request is
//   taken only in IDLE; the single-port stack memory serves the two word
//   accesses plus a read return. Reset: synchronous, active low; then a
//   clearing pass zeroes the memory, in_ready low; frame pointer at the base.
// ----------------------------------------------------------------------------
module call_frame_stack_core #(
  parameter int unsigned STACK_WORDS = cfs_pkg::STACK_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfs_pkg::cfs_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cfs_pkg::cfs_res_t out_data
);

  localparam int AW  = $clog2(STACK_WORDS);
  // slot address width: covers fp + header + largest index
  localparam int SLW = ((AW > 8) ? AW : 8) + 2;
  localparam logic [SLW-1:0] SW_S    = SLW'(STACK_WORDS);
  localparam logic [AW-1:0]  FP_BASE = AW'(STACK_WORDS - 1);

  // Sequencer: clear pass after reset, then per request
  // IDLE (first access) -> SECOND (second access) -> FINISH (result).
  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SECOND = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] fp_r, fp_nxt;
  logic [AW-1:0] clr_addr_r;

  // request context kept across the sequence
  logic [2:0]    kind_r;
  logic [1:0]    err_r;
  logic          two_r;
  logic          we_r;
  logic [AW-1:0] addr1_r;
  logic [31:0]   wd1_r;
  logic [31:0]   lo_r;

  logic              out_valid_r;
  cfs_pkg::cfs_res_t out_data_r;

  // memory port
  logic          mem_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  // decode of the incoming request
  logic           in_fire;
  logic [SLW-1:0] slot;
  logic [SLW-1:0] need;
  logic [AW-1:0]  nfp;
  logic           acc_go;
  logic           acc_two;
  logic           acc_we;
  logic [1:0]     acc_err;
  logic [AW-1:0]  addr0;
  logic [AW-1:0]  addr1;
  logic [31:0]    wd0;
  logic [31:0]    wd1;

  logic              fin_go;
  cfs_pkg::cfs_res_t res;
  logic              ret_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Bounds and addresses are settled at accept time from the live fp.
  always_comb begin
    slot    = SLW'(fp_r) + SLW'(cfs_pkg::HEADER_WORDS) + SLW'(in_data.index);
    need    = SLW'(in_data.locals_count) + SLW'(cfs_pkg::HEADER_WORDS);
    nfp     = fp_r - AW'(need);
    acc_go  = 1'b0;
    acc_two = 1'b0;
    acc_we  = 1'b0;
    acc_err = cfs_pkg::ERR_OK;
    addr0   = slot[AW-1:0];
    addr1   = slot[AW-1:0] + AW'(1);
    wd0     = in_data.value_low;
    wd1     = in_data.value_high;
    case (in_data.kind)
      cfs_pkg::KIND_CALL: begin
        // new frame: saved fp at nfp, return address at nfp + 1
        addr0 = nfp;
        addr1 = nfp + AW'(1);
        wd0   = 32'(fp_r);
        wd1   = in_data.return_address;
        if (SLW'(fp_r) <= need) begin
          acc_err = cfs_pkg::ERR_OVERFLOW;
        end else begin
          acc_go  = 1'b1;
          acc_two = 1'b1;
          acc_we  = 1'b1;
        end
      end
      cfs_pkg::KIND_RETURN: begin
        addr0 = fp_r;
        addr1 = fp_r + AW'(1);
        if (fp_r == FP_BASE) begin
          acc_err = cfs_pkg::ERR_UNDERFLOW;
        end else begin
          acc_go  = 1'b1;
          acc_two = 1'b1;
        end
      end
      cfs_pkg::KIND_READ_WORD: begin
        if (slot >= SW_S) begin
          acc_err = cfs_pkg::ERR_SCOPE;
        end else begin
          acc_go = 1'b1;
        end
      end
      cfs_pkg::KIND_READ_DWORD: begin
        // both words must lie inside the memory
        if (slot >= SW_S - SLW'(1)) begin
          acc_err = cfs_pkg::ERR_SCOPE;
        end else begin
          acc_go  = 1'b1;
          acc_two = 1'b1;
        end
      end
      cfs_pkg::KIND_WRITE_WORD: begin
        if (slot >= SW_S) begin
          acc_err = cfs_pkg::ERR_SCOPE;
        end else begin
          acc_go = 1'b1;
          acc_we = 1'b1;
        end
      end
      cfs_pkg::KIND_WRITE_DWORD: begin
        if (slot >= SW_S - SLW'(1)) begin
          acc_err = cfs_pkg::ERR_SCOPE;
        end else begin
          acc_go  = 1'b1;
          acc_two = 1'b1;
          acc_we  = 1'b1;
        end
      end
      default: begin
        // unused kinds: no access, all-zero answer
      end
    endcase
  end

  // Memory port arbitration: clear sweep, first access, second access.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr1_r;
    mem_wdata = wd1_r;
    case (state_r)
      S_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_en    = in_fire && acc_go;
        mem_we    = acc_we;
        mem_addr  = addr0;
        mem_wdata = wd0;
      end
      S_SECOND: begin
        mem_en = two_r;
        mem_we = we_r;
      end
      default: begin
      end
    endcase
  end

  cfs_spram #(
    .DEPTH (STACK_WORDS)
  ) u_stack_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Result formed in FINISH: lo_r holds the first word read, mem_rdata the
  // second. A return whose saved pointer lies outside the memory is refused.
  assign fin_go = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign ret_ok = (lo_r < 32'(STACK_WORDS));

  always_comb begin
    res       = '0;
    res.error = err_r;
    if (err_r == cfs_pkg::ERR_OK) begin
      case (kind_r)
        cfs_pkg::KIND_READ_WORD: begin
          res.read_low = lo_r;
        end
        cfs_pkg::KIND_READ_DWORD: begin
          res.read_low  = lo_r;
          res.read_high = mem_rdata;
        end
        cfs_pkg::KIND_RETURN: begin
          if (ret_ok) begin
            res.resume_address = mem_rdata;
          end else begin
            res.error = cfs_pkg::ERR_UNDERFLOW;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    fp_nxt    = fp_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == FP_BASE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SECOND;
          if ((in_data.kind == cfs_pkg::KIND_CALL) && acc_go) begin
            fp_nxt = nfp;
          end
        end
      end
      S_SECOND: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
          if ((kind_r == cfs_pkg::KIND_RETURN) && (err_r == cfs_pkg::ERR_OK) && ret_ok) begin
            fp_nxt = lo_r[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      fp_r        <= FP_BASE;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fp_r    <= fp_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and context registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_data.kind;
      err_r   <= acc_err;
      two_r   <= acc_two;
      we_r    <= acc_we;
      addr1_r <= addr1;
      wd1_r   <= wd1;
    end
    if (state_r == S_SECOND) begin
      lo_r <= mem_rdata;
    end
    if (fin_go) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // frame pointer always addresses a word of the memory
  a_fp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fp_r <= FP_BASE)
    else $error("frame pointer beyond stack memory");

  // no request taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("request accepted while clearing");

  // an accepted request always moves on to its second access
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_SECOND))
    else $error("sequencer did not advance after accept");

  // finishing always presents a result
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished request produced no result");

  // memory is idle while a result waits for the output slot
  a_wait_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FINISH) && !fin_go) |-> !mem_en)
    else $error("memory access while stalled in finish");
`endif

endmodule

// ===== hdl/cfs_spram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfs_spram
// Single-port word memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module cfs_spram #(
  parameter int unsigned DEPTH = cfs_pkg::STACK_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [31:0]              wdata,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
